[sv/ssp_pkg.sv]
package ssp_pkg;

    localparam int STATUS_W = 2;
    localparam int SLOT_OUT_W = 10;
    localparam int LIVE_OUT_W = 11;
    localparam int ENTITY_W = 16;
    localparam int DATA_W = 32;

    localparam logic [STATUS_W-1:0] ST_APPENDED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERWRITTEN = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REMOVED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd3;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef struct packed {
        logic                operation;
        logic [ENTITY_W-1:0] entity_id;
        logic [DATA_W-1:0]   component_data;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [SLOT_OUT_W-1:0] slot_index;
        logic [LIVE_OUT_W-1:0] live_count;
    } result_t;

    // controller -> datapath
    typedef struct packed {
        logic clear;
        logic load_item;
        logic lookup;
        logic exec;
        logic relink;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clear_done;
        logic relink_needed;
    } sts_t;

endpackage

[sv/ssp_ram.sv]
module ssp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/ssp_datapath.sv]
module ssp_datapath #(
    parameter int ENTITY_COUNT = 1024,
    parameter int COMPONENT_BITS = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  ssp_pkg::cmd_t    cmd,
    output ssp_pkg::sts_t    sts,
    input  ssp_pkg::item_t   item,
    output ssp_pkg::result_t result
);

    import ssp_pkg::*;

    localparam int IDX_W = $clog2(ENTITY_COUNT);
    localparam int CNT_W = IDX_W + 1;
    localparam int MAP_W = IDX_W + 1;
    localparam logic [ENTITY_W:0] ENT_LIMIT = (ENTITY_W + 1)'(ENTITY_COUNT);
    localparam logic [IDX_W-1:0] LAST_ENTRY = IDX_W'(ENTITY_COUNT - 1);

    logic                      op_reg;
    logic [ENTITY_W-1:0]       ent_reg;
    logic [COMPONENT_BITS-1:0] data_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic [IDX_W-1:0]          clr_cnt_reg;
    result_t                   result_reg;
    result_t                   result_next;

    logic                      map_wr_en;
    logic [IDX_W-1:0]          map_wr_addr;
    logic [MAP_W-1:0]          map_wr_data;
    logic [MAP_W-1:0]          map_rd;
    logic                      pay_wr_en;
    logic [IDX_W-1:0]          pay_wr_addr;
    logic [COMPONENT_BITS-1:0] pay_wr_data;
    logic [COMPONENT_BITS-1:0] pay_rd;
    logic                      own_wr_en;
    logic [IDX_W-1:0]          own_wr_addr;
    logic [IDX_W-1:0]          own_wr_data;
    logic [IDX_W-1:0]          own_rd;

    logic             in_range;
    logic [IDX_W-1:0] ent_idx;
    logic             hit;
    logic [IDX_W-1:0] slot;
    logic [CNT_W-1:0] last;
    logic [IDX_W-1:0] last_idx;
    logic [IDX_W-1:0] count_idx;
    logic             do_append;
    logic             do_overwrite;
    logic             do_remove;
    logic             do_move;

    assign in_range = {1'b0, ent_reg} < ENT_LIMIT;
    assign ent_idx = ent_reg[IDX_W-1:0];
    assign hit = map_rd[IDX_W];
    assign slot = map_rd[IDX_W-1:0];
    assign last = count_reg - CNT_W'(1);
    assign last_idx = last[IDX_W-1:0];
    assign count_idx = count_reg[IDX_W-1:0];

    assign do_append = in_range && (op_reg == OP_INSERT) && !hit;
    assign do_overwrite = in_range && (op_reg == OP_INSERT) && hit;
    assign do_remove = in_range && (op_reg == OP_REMOVE) && hit && (count_reg != '0);
    // removing the last live slot needs no move
    assign do_move = do_remove && (slot != last_idx);

    assign sts.clear_done = (clr_cnt_reg == LAST_ENTRY);
    assign sts.relink_needed = do_move;

    always_comb
    begin
        result_next.status = ST_IGNORED;
        result_next.slot_index = '0;
        count_next = count_reg;
        if (do_append)
        begin
            result_next.status = ST_APPENDED;
            result_next.slot_index = SLOT_OUT_W'(count_idx);
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_overwrite)
        begin
            result_next.status = ST_OVERWRITTEN;
            result_next.slot_index = SLOT_OUT_W'(slot);
        end
        else if (do_remove)
        begin
            result_next.status = ST_REMOVED;
            result_next.slot_index = SLOT_OUT_W'(slot);
            count_next = last;
        end
        result_next.live_count = LIVE_OUT_W'(count_next);
    end

    always_comb
    begin
        map_wr_en = 1'b0;
        map_wr_addr = ent_idx;
        map_wr_data = '0;
        pay_wr_en = 1'b0;
        pay_wr_addr = slot;
        pay_wr_data = data_reg;
        own_wr_en = 1'b0;
        own_wr_addr = slot;
        own_wr_data = own_rd;

        if (cmd.clear)
        begin
            map_wr_en = 1'b1;
            map_wr_addr = clr_cnt_reg;
        end
        else if (cmd.exec)
        begin
            if (do_append)
            begin
                map_wr_en = 1'b1;
                map_wr_data = {1'b1, count_idx};
                pay_wr_en = 1'b1;
                pay_wr_addr = count_idx;
                own_wr_en = 1'b1;
                own_wr_addr = count_idx;
                own_wr_data = ent_idx;
            end
            else if (do_overwrite)
            begin
                pay_wr_en = 1'b1;
            end
            else if (do_remove)
            begin
                map_wr_en = 1'b1;
                if (do_move)
                begin
                    pay_wr_en = 1'b1;
                    pay_wr_data = pay_rd;
                    own_wr_en = 1'b1;
                end
            end
        end
        else if (cmd.relink)
        begin
            // moved entity now lives in the freed slot
            map_wr_en = 1'b1;
            map_wr_addr = own_rd;
            map_wr_data = {1'b1, slot};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            clr_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
            end
            if (cmd.exec)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg <= item.operation;
            ent_reg <= item.entity_id;
            data_reg <= COMPONENT_BITS'(item.component_data);
        end
        if (cmd.exec)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

    ssp_ram #(
        .WIDTH(MAP_W),
        .DEPTH(ENTITY_COUNT)
    ) u_map_ram (
        .clk    (clk),
        .wr_en  (map_wr_en),
        .wr_addr(map_wr_addr),
        .wr_data(map_wr_data),
        .rd_en  (cmd.lookup),
        .rd_addr(ent_idx),
        .rd_data(map_rd)
    );

    ssp_ram #(
        .WIDTH(COMPONENT_BITS),
        .DEPTH(ENTITY_COUNT)
    ) u_payload_ram (
        .clk    (clk),
        .wr_en  (pay_wr_en),
        .wr_addr(pay_wr_addr),
        .wr_data(pay_wr_data),
        .rd_en  (cmd.lookup),
        .rd_addr(last_idx),
        .rd_data(pay_rd)
    );

    ssp_ram #(
        .WIDTH(IDX_W),
        .DEPTH(ENTITY_COUNT)
    ) u_owner_ram (
        .clk    (clk),
        .wr_en  (own_wr_en),
        .wr_addr(own_wr_addr),
        .wr_data(own_wr_data),
        .rd_en  (cmd.lookup),
        .rd_addr(last_idx),
        .rd_data(own_rd)
    );

endmodule

[sv/ssp_ctrl.sv]
module ssp_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_stall,
    output logic          result_valid,
    input  logic          result_stall,
    output ssp_pkg::cmd_t cmd,
    input  ssp_pkg::sts_t sts
);

    import ssp_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_EXEC,
        S_RELINK
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   result_valid_reg;
    logic   result_valid_next;
    logic   out_free;

    assign out_free = !result_valid_reg || !result_stall;
    assign item_stall = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        result_valid_next = result_valid_reg && result_stall;
        cmd = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                // commit only once the result register can take the beat
                if (out_free)
                begin
                    cmd.exec = 1'b1;
                    result_valid_next = 1'b1;
                    state_next = sts.relink_needed ? S_RELINK : S_IDLE;
                end
            end
            S_RELINK:
            begin
                cmd.relink = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

endmodule

[sv/sparse_set_swap_pop_pool_top.sv]
// channel  | dir | handshake            | beat
// item     | in  | item_valid/stall     | operation, entity_id, component_data
// result   | out | result_valid/stall   | status, slot_index, live_count
//
// Each item passes through accept, lookup and commit; a remove that moves the
// last live slot adds a relink step, the second write to the map RAM.
// After reset the map RAM is swept to invalid, one entry a cycle, and the block
// takes no item until the sweep is done.
// A stalled result holds the commit cycle until the result register frees up.
module sparse_set_swap_pop_pool_top #(
    parameter int ENTITY_COUNT = 1024,
    parameter int COMPONENT_BITS = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  ssp_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output ssp_pkg::result_t result
);

    import ssp_pkg::*;

    cmd_t cmd;
    sts_t sts;

    ssp_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .cmd         (cmd),
        .sts         (sts)
    );

    ssp_datapath #(
        .ENTITY_COUNT  (ENTITY_COUNT),
        .COMPONENT_BITS(COMPONENT_BITS)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .sts   (sts),
        .item  (item),
        .result(result)
    );

endmodule

[sv/ssp_checker.sv]
module ssp_assertions (
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_stall,
    input logic             result_valid,
    input logic             result_stall,
    input ssp_pkg::result_t result
);

    import ssp_pkg::*;

    logic item_acc;

    assign item_acc = item_valid && !item_stall;

    // a stalled result beat holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    // an accepted item keeps the input closed through lookup and commit
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_acc |=> item_stall ##1 item_stall)
        else $error("item taken while previous one in flight");

    // ignored items report slot zero
    a_ignored_slot: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status == ST_IGNORED) |-> (result.slot_index == '0))
        else $error("ignored result with nonzero slot");

endmodule

bind sparse_set_swap_pop_pool_top ssp_assertions u_ssp_assertions (.*);
